/* src/i2ctrf_pkg.sv */
`default_nettype none

package i2ctrf_pkg;

  // Store geometry. Every store address is an 8-bit value taken modulo the depth.
  localparam int STORE_DEPTH = 256;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // Bus event codes carried on the mode field.
  localparam logic [1:0] MODE_WADDR = 2'd0;
  localparam logic [1:0] MODE_WDATA = 2'd1;
  localparam logic [1:0] MODE_RADDR = 2'd2;

  // Configuration register indexes.
  localparam int         CFG_IDX_W        = 2;
  localparam logic [1:0] CFG_INDEX_SLOT   = 2'd0;
  localparam logic [1:0] CFG_CHANGE_SLOT  = 2'd1;
  localparam logic [1:0] CFG_CHANGE_VALUE = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MARK,
    S_READ
  } state_t;

  // One access request to the single-port store.
  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } store_req_t;

  function automatic logic [ADDR_W-1:0] store_addr(input logic [7:0] a);
    logic [8:0] wide;
    wide = 9'({1'b0, a} % STORE_DEPTH);
    return wide[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* src/i2c_target_register_file.sv */
`default_nettype none

// Byte-level target side of an I2C register file backed by a 256-byte store.
// One item is one bus event on mode/rx_byte: a write address match, a received
// write byte, or a read address match. An item is accepted at a rising edge
// with start high and busy low. Every item yields exactly one result, shown on
// tx_byte, tx_valid and data_written for a single cycle while done is high.
// The receiver cannot stall, so results are never held back.
// Latency and throughput: an address match, an index byte or an ignored event
// takes one store access at most; its result appears in the cycle after
// acceptance and busy stays low, so such items can arrive every cycle. A data
// byte makes two writes to the single-port store (the byte, then the change
// mark) and a read waits for registered read data; both keep busy high
// in S_MARK or S_READ and register their result from that state, so no new
// item is taken until busy falls. The single store port splits the two writes.
// Configuration registers are written through cfg_we/cfg_index/cfg_data at any
// edge and are registered; they should be written while no item is open.
// Reset (synchronous, active high) restores the register defaults, clears the
// pointer and both flags, and clears the per-entry valid bits of the store at
// once, so every entry reads as zero without a clearing pass.

module i2c_target_register_file
  import i2ctrf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           mode,
  input  wire logic [7:0]           rx_byte,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data,
  output logic                      done,
  output logic [7:0]                tx_byte,
  output logic                      tx_valid,
  output logic                      data_written
);

  state_t     state, state_next;
  store_req_t req;
  logic [7:0] rd_data;

  logic [7:0] pointer, pointer_next;
  logic       expect_index, expect_index_next;
  logic       expect_data, expect_data_next;
  logic [7:0] index_slot, change_slot, change_value;

  logic       done_next;
  logic [7:0] tx_byte_next;
  logic       tx_valid_next;
  logic       data_written_next;

  i2ctrf_store u_store (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rdata (rd_data)
  );

  assign busy = (state != S_IDLE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      index_slot   <= 8'd1;
      change_slot  <= 8'd2;
      change_value <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INDEX_SLOT:   index_slot   <= cfg_data;
        CFG_CHANGE_SLOT:  change_slot  <= cfg_data;
        CFG_CHANGE_VALUE: change_value <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pointer      <= 8'd0;
      expect_index <= 1'b0;
      expect_data  <= 1'b0;
      done         <= 1'b0;
    end else begin
      state        <= state_next;
      pointer      <= pointer_next;
      expect_index <= expect_index_next;
      expect_data  <= expect_data_next;
      done         <= done_next;
    end
  end

  // Result payload needs no reset; it is only looked at while done is high.
  always_ff @(posedge clk) begin
    tx_byte      <= tx_byte_next;
    tx_valid     <= tx_valid_next;
    data_written <= data_written_next;
  end

  always_comb begin
    state_next        = state;
    req               = '0;
    pointer_next      = pointer;
    expect_index_next = expect_index;
    expect_data_next  = expect_data;
    done_next         = 1'b0;
    tx_byte_next      = tx_byte;
    tx_valid_next     = tx_valid;
    data_written_next = data_written;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          tx_byte_next      = 8'd0;
          tx_valid_next     = 1'b0;
          data_written_next = 1'b0;
          case (mode)
            MODE_WADDR: begin
              // A repeated match only rearms the index byte.
              expect_index_next = 1'b1;
              done_next         = 1'b1;
            end
            MODE_WDATA: begin
              if (expect_index) begin
                // Index byte: record it and move the pointer by it.
                req               = '{en: 1'b1, we: 1'b1,
                                      addr: store_addr(index_slot), wdata: rx_byte};
                pointer_next      = pointer + rx_byte;
                expect_index_next = 1'b0;
                expect_data_next  = 1'b1;
                done_next         = 1'b1;
              end else if (expect_data) begin
                // Data byte goes in first; the change mark follows next cycle
                // so that it wins when both land on the same entry.
                req        = '{en: 1'b1, we: 1'b1,
                               addr: store_addr(pointer), wdata: rx_byte};
                state_next = S_MARK;
              end else begin
                done_next = 1'b1;
              end
            end
            MODE_RADDR: begin
              req          = '{en: 1'b1, we: 1'b0,
                               addr: store_addr(pointer), wdata: 8'd0};
              pointer_next = 8'd0;
              state_next   = S_READ;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      S_MARK: begin
        req               = '{en: 1'b1, we: 1'b1,
                              addr: store_addr(change_slot), wdata: change_value};
        pointer_next      = 8'd0;
        expect_index_next = 1'b0;
        expect_data_next  = 1'b0;
        data_written_next = 1'b1;
        done_next         = 1'b1;
        state_next        = S_IDLE;
      end
      S_READ: begin
        tx_byte_next  = rd_data;
        tx_valid_next = 1'b1;
        done_next     = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/i2ctrf_store.sv */
`default_nettype none

module i2ctrf_store
  import i2ctrf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire store_req_t req,
  output logic [7:0]      rdata
);

  logic [7:0]             mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] valid;
  logic [7:0]             mem_q;
  logic                   valid_q;

  // Entries never written since reset read back as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.en && req.we) begin
      valid[req.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        mem_q   <= mem[req.addr];
        valid_q <= valid[req.addr];
      end
    end
  end

  assign rdata = valid_q ? mem_q : 8'd0;

endmodule

`default_nettype wire
